// File: hdl/gcl_pkg.sv
package gcl_pkg;

	// Width of every operand and result field on the stream ports
	localparam int FIELD_W = 64;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} gcl_state_t;

	// Requests from the stream side to the engine
	typedef struct packed {
		logic start;
		logic ack;
	} gcl_ctrl_t;

	// Status from the engine to the stream side
	typedef struct packed {
		logic idle;
		logic done;
	} gcl_stat_t;

endpackage

// File: hdl/gcl_engine.sv
module gcl_engine import gcl_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gcl_ctrl_t        ctrl,
	input  logic [WIDTH-1:0] operand_a,
	input  logic [WIDTH-1:0] operand_b,
	output gcl_stat_t        stat,
	output logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] multiple,
	output logic             multiple_overflow
);

	localparam int CW = $clog2(WIDTH);

	gcl_state_t state_q, state_d;

	logic [WIDTH-1:0] a_q, b_q, u_q, v_q, g_q, rem_q, quo_q, acc_q;
	logic [CW-1:0]    k_q, cnt_q;
	logic             ovf_q;

	// Shared adder / subtractor
	logic [WIDTH+1:0] add_x, add_y, add_res;
	logic             add_sub;

	logic [WIDTH:0] rem_sh;
	logic           q_bit, gcd_end, mul_ovf, last_bit, start_zero;

	assign add_res    = add_x + (add_sub ? ~add_y : add_y) + (WIDTH+2)'(add_sub);
	assign rem_sh     = {rem_q, quo_q[WIDTH-1]};
	assign q_bit      = !add_res[WIDTH+1];
	assign gcd_end    = (u_q == '0) || (v_q == '0);
	assign mul_ovf    = ovf_q || (add_res[WIDTH+1:WIDTH] != 2'b00);
	assign last_bit   = (cnt_q == '0);
	assign start_zero = (operand_a == '0) || (operand_b == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctrl.start) state_d = start_zero ? ST_DONE : ST_GCD;
			end
			ST_GCD: begin
				if (gcd_end) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (last_bit) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (last_bit) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (ctrl.ack) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Adder operand selection and status
	always_comb begin
		add_x     = '0;
		add_y     = '0;
		add_sub   = 1'b0;
		stat.idle = (state_q == ST_IDLE);
		stat.done = (state_q == ST_DONE);
		case (state_q)
			ST_GCD: begin
				add_x   = {2'b00, u_q};
				add_y   = {2'b00, v_q};
				add_sub = 1'b1;
			end
			ST_DIV: begin
				add_x   = {1'b0, rem_sh};
				add_y   = {2'b00, g_q};
				add_sub = 1'b1;
			end
			ST_MUL: begin
				add_x   = {1'b0, acc_q, 1'b0};
				add_y   = quo_q[WIDTH-1] ? {2'b00, b_q} : '0;
				add_sub = 1'b0;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// Load operands; a zero operand leaves the final answer in place
				if (ctrl.start) begin
					a_q   <= operand_a;
					b_q   <= operand_b;
					u_q   <= operand_a;
					v_q   <= operand_b;
					k_q   <= '0;
					g_q   <= operand_a | operand_b;
					acc_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_GCD: begin
				// Binary Euclid: strip common twos, halve even values, subtract odd ones
				if (gcd_end) begin
					g_q   <= (u_q | v_q) << k_q;
					rem_q <= '0;
					quo_q <= a_q;
					cnt_q <= CW'(WIDTH-1);
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (add_res[WIDTH+1]) begin
					u_q <= v_q;
					v_q <= u_q;
				end else begin
					u_q <= add_res[WIDTH-1:0];
				end
			end
			ST_DIV: begin
				// Restoring division a / gcd, one quotient bit per cycle
				rem_q <= q_bit ? add_res[WIDTH-1:0] : rem_sh[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], q_bit};
				if (last_bit) begin
					cnt_q <= CW'(WIDTH-1);
					acc_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_MUL: begin
				// Shift-add multiply quotient by b, MSB first; overflow is sticky
				acc_q <= add_res[WIDTH-1:0];
				ovf_q <= mul_ovf;
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign divisor           = g_q;
	assign multiple          = ovf_q ? '1 : acc_q;
	assign multiple_overflow = ovf_q;

endmodule

// File: hdl/gcd_lcm_unit.sv
// Sequence: load, a data-dependent binary Euclid phase, restoring division and
//   shift-add multiplication, then a hand-off of the result to the output register.
// Throughput: one item at a time; a new item is accepted only once the engine is
//   idle again. The Euclid, division and multiplication phases share the single adder.
// Reset: arst_n clears the sequencer and the output valid flag; data registers keep
//   whatever they held.
module gcd_lcm_unit import gcl_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [2*FIELD_W-1:0] s_axis_tdata,  // operand_a, operand_b
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [2*FIELD_W-1:0] m_axis_tdata,  // divisor, multiple
	output logic                 m_axis_tuser   // multiple_overflow
);

	gcl_ctrl_t        ctrl;
	gcl_stat_t        stat;
	logic [WIDTH-1:0] eng_divisor, eng_multiple;
	logic             eng_ovf;

	logic [2*FIELD_W-1:0] out_data_q;
	logic                 out_ovf_q;
	logic                 out_valid_q;

	// Start on an input transfer; release the engine once the output slot frees
	assign s_axis_tready = stat.idle;
	assign ctrl.start    = s_axis_tvalid && s_axis_tready;
	assign ctrl.ack      = stat.done && (!out_valid_q || m_axis_tready);

	gcl_engine #(
		.WIDTH(WIDTH)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.operand_a        (s_axis_tdata[WIDTH-1:0]),
		.operand_b        (s_axis_tdata[FIELD_W +: WIDTH]),
		.stat             (stat),
		.divisor          (eng_divisor),
		.multiple         (eng_multiple),
		.multiple_overflow(eng_ovf)
	);

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (ctrl.ack) begin
			out_data_q <= {FIELD_W'(eng_multiple), FIELD_W'(eng_divisor)};
			out_ovf_q  <= eng_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule

// File: hdl/gcl_checker.sv
module gcl_checker import gcl_pkg::*; #(
	parameter int WIDTH = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [2*FIELD_W-1:0] s_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [2*FIELD_W-1:0] m_axis_tdata,
	input logic                 m_axis_tuser
);

	localparam logic [FIELD_W-1:0] MASK = FIELD_W'((65'd1 << WIDTH) - 65'd1);

	logic [FIELD_W-1:0] chk_div, chk_mul;

	assign chk_div = m_axis_tdata[FIELD_W-1:0];
	assign chk_mul = m_axis_tdata[2*FIELD_W-1:FIELD_W];

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// One item at a time: the input closes after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready while an item is in work");

	// Overflow means a saturated multiple
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> chk_mul == MASK)
		else $error("overflow without saturated multiple");

	// A zero divisor comes only from two zero operands
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && chk_div == '0 |-> chk_mul == '0 && !m_axis_tuser)
		else $error("zero divisor with nonzero multiple");

endmodule

bind gcd_lcm_unit gcl_checker #(.WIDTH(WIDTH)) u_gcl_checker (.*);
